/* hdl/rgb_to_hsv_macros.svh */
// Assertion macros shared by the color conversion RTL.
// Needs no other file; the asserting modules take it by include.
`ifndef RGB_TO_HSV_MACROS_SVH
`define RGB_TO_HSV_MACROS_SVH

// Checked at every clock edge outside reset.
`define R2H_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define R2H_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

/* hdl/r2h_pkg.sv */
// Types shared by the RGB to HSV conversion block.
// Has no dependencies; rgb_to_hsv.sv refers to it by scoped names.
`default_nettype none

package r2h_pkg;

   // Which channel is the largest; ties go red, then green, then blue.
   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

endpackage

`default_nettype wire

/* hdl/rgb_to_hsv.sv */
// RGBA to HSVA pixel conversion: a compare prologue and two pipelined dividers.
// Depends on r2h_pkg.sv and rgb_to_hsv_macros.svh.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   req_    | in        | req_tvalid/req_tready  | red, green, blue, alpha
//   rsp_    | out       | rsp_tvalid/rsp_tready  | hue, saturation, value, alpha_out
//
// One pixel may enter every clock cycle. Three stages find max, min, chroma and the hue
// numerator, then each divider stage resolves one quotient bit of hue, of saturation,
// or of both.
// The whole pipeline advances together whenever the output register is empty or
// being taken, so a stall at rsp_ freezes every stage and req_tready drops.
// Reset (synchronous) clears the valid bits only; data registers are not reset.
`default_nettype none
`include "rgb_to_hsv_macros.svh"

module rgb_to_hsv #(
   parameter int CHANNEL_BITS = 8,
   parameter int HUE_BITS     = 16,
   localparam int REQ_W = ((4 * CHANNEL_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((HUE_BITS + 3 * CHANNEL_BITS + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // red, green, blue, alpha (CHANNEL_BITS each), zero padded
   input  wire logic [REQ_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // hue (HUE_BITS), saturation, value, alpha_out (CHANNEL_BITS each), zero padded
   output logic [RSP_W-1:0]      rsp_tdata
);

   localparam int C         = CHANNEL_BITS;
   localparam int H         = HUE_BITS;
   localparam int HD_W      = C + 3;
   localparam int DIV_STEPS = (H > C) ? H : C;

   logic adv;

   // Input field unpacking.
   logic [C-1:0] red, green, blue, alpha;
   assign red   = req_tdata[0 +: C];
   assign green = req_tdata[C +: C];
   assign blue  = req_tdata[2*C +: C];
   assign alpha = req_tdata[3*C +: C];

   // The pipeline moves as one whenever the output slot is free.
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // ---------------- Stage 1: max, min, sector and channel difference.
   logic                s1_valid_ff;
   logic [C-1:0]        s1_mx_ff, s1_mx_in, s1_mn_ff, s1_mn_in, s1_alpha_ff;
   r2h_pkg::sector_type s1_sector_ff, s1_sector_in;
   logic signed [C:0]   s1_diff_ff, s1_diff_in;

   always_comb begin
      s1_mx_in = red;
      s1_mn_in = red;
      if (green > s1_mx_in) s1_mx_in = green;
      if (blue > s1_mx_in) s1_mx_in = blue;
      if (green < s1_mn_in) s1_mn_in = green;
      if (blue < s1_mn_in) s1_mn_in = blue;
      priority if (red >= green && red >= blue) begin
         s1_sector_in = r2h_pkg::SECT_RED;
         s1_diff_in   = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (green >= blue) begin
         s1_sector_in = r2h_pkg::SECT_GREEN;
         s1_diff_in   = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         s1_sector_in = r2h_pkg::SECT_BLUE;
         s1_diff_in   = $signed({1'b0, red}) - $signed({1'b0, green});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_tvalid;
      end
      if (adv) begin
         s1_mx_ff     <= s1_mx_in;
         s1_mn_ff     <= s1_mn_in;
         s1_sector_ff <= s1_sector_in;
         s1_diff_ff   <= s1_diff_in;
         s1_alpha_ff  <= alpha;
      end
   end

   // ---------------- Stage 2: chroma.
   logic                s2_valid_ff;
   logic [C-1:0]        s2_chroma_ff, s2_chroma_in, s2_mx_ff, s2_alpha_ff;
   r2h_pkg::sector_type s2_sector_ff;
   logic signed [C:0]   s2_diff_ff;

   assign s2_chroma_in = s1_mx_ff - s1_mn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         s2_chroma_ff <= s2_chroma_in;
         s2_mx_ff     <= s1_mx_ff;
         s2_sector_ff <= s1_sector_ff;
         s2_diff_ff   <= s1_diff_ff;
         s2_alpha_ff  <= s1_alpha_ff;
      end
   end

   // ---------------- Stage 3: hue numerator, divisors and saturation dividend.
   logic              s3_valid_ff;
   logic [HD_W-1:0]   s3_num_ff, s3_num_in, s3_hdiv_ff, s3_hdiv_in;
   logic [C-1:0]      s3_srem_ff, s3_slo_ff, s3_sdiv_ff, s3_sdiv_in, s3_mx_ff, s3_alpha_ff;
   logic [HD_W-1:0]   six_c, sector_off, diff_ext;
   logic [2*C-1:0]    sat_dividend;

   always_comb begin
      six_c    = {s2_chroma_ff, 3'b000} - {2'b00, s2_chroma_ff, 1'b0};
      diff_ext = {{2{s2_diff_ff[C]}}, s2_diff_ff};
      unique case (s2_sector_ff)
         r2h_pkg::SECT_RED:   sector_off = s2_diff_ff[C] ? six_c : '0;
         r2h_pkg::SECT_GREEN: sector_off = {2'b00, s2_chroma_ff, 1'b0};
         r2h_pkg::SECT_BLUE:  sector_off = {1'b0, s2_chroma_ff, 2'b00};
         default:             sector_off = '0;
      endcase
      // The numerator always lands in 0 .. 6*chroma-1, so modular add is exact.
      s3_num_in  = sector_off + diff_ext;
      // A zero divisor only occurs with a zero dividend; one gives a zero quotient.
      s3_hdiv_in = (s2_chroma_ff == '0) ? HD_W'(1) : six_c;
      s3_sdiv_in = (s2_mx_ff == '0) ? C'(1) : s2_mx_ff;
      // chroma * (2^C - 1); its upper half is below the value, so C bits of quotient.
      sat_dividend = {s2_chroma_ff, {C{1'b0}}} - {{C{1'b0}}, s2_chroma_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (adv) begin
         s3_num_ff   <= s3_num_in;
         s3_hdiv_ff  <= s3_hdiv_in;
         s3_srem_ff  <= sat_dividend[2*C-1:C];
         s3_slo_ff   <= sat_dividend[C-1:0];
         s3_sdiv_ff  <= s3_sdiv_in;
         s3_mx_ff    <= s2_mx_ff;
         s3_alpha_ff <= s2_alpha_ff;
      end
   end

   // Divider stages: one quotient bit of each unfinished division per stage.
   logic [DIV_STEPS-1:0] dv_valid_ff;
   logic [HD_W-1:0]      dv_hrem_ff  [DIV_STEPS];
   logic [HD_W-1:0]      dv_hdiv_ff  [DIV_STEPS];
   logic [H-1:0]         dv_hq_ff    [DIV_STEPS];
   logic [C-1:0]         dv_srem_ff  [DIV_STEPS];
   logic [C-1:0]         dv_slo_ff   [DIV_STEPS];
   logic [C-1:0]         dv_sdiv_ff  [DIV_STEPS];
   logic [C-1:0]         dv_mx_ff    [DIV_STEPS];
   logic [C-1:0]         dv_alpha_ff [DIV_STEPS];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      logic            valid_prev;
      logic [HD_W-1:0] hrem_prev, hdiv_prev, hrem_in;
      logic [H-1:0]    hq_prev, hq_in;
      logic [C-1:0]    srem_prev, slo_prev, sdiv_prev, mx_prev, alpha_prev;
      logic [C-1:0]    srem_in, slo_in;
      logic [HD_W:0]   htrial;
      logic [C:0]      strial;

      if (i == 0) begin : g_first
         assign valid_prev = s3_valid_ff;
         assign hrem_prev  = s3_num_ff;
         assign hdiv_prev  = s3_hdiv_ff;
         assign hq_prev    = '0;
         assign srem_prev  = s3_srem_ff;
         assign slo_prev   = s3_slo_ff;
         assign sdiv_prev  = s3_sdiv_ff;
         assign mx_prev    = s3_mx_ff;
         assign alpha_prev = s3_alpha_ff;
      end else begin : g_next
         assign valid_prev = dv_valid_ff[i-1];
         assign hrem_prev  = dv_hrem_ff[i-1];
         assign hdiv_prev  = dv_hdiv_ff[i-1];
         assign hq_prev    = dv_hq_ff[i-1];
         assign srem_prev  = dv_srem_ff[i-1];
         assign slo_prev   = dv_slo_ff[i-1];
         assign sdiv_prev  = dv_sdiv_ff[i-1];
         assign mx_prev    = dv_mx_ff[i-1];
         assign alpha_prev = dv_alpha_ff[i-1];
      end

      assign htrial = {hrem_prev, 1'b0};
      assign strial = {srem_prev, slo_prev[C-1]};

      // Restoring step for hue; past the last hue bit the stage only carries data.
      always_comb begin
         hrem_in = hrem_prev;
         hq_in   = hq_prev;
         if (i < H) begin
            if (htrial >= {1'b0, hdiv_prev}) begin
               hrem_in = HD_W'(htrial - {1'b0, hdiv_prev});
               hq_in   = {hq_prev[H-2:0], 1'b1};
            end else begin
               hrem_in = htrial[HD_W-1:0];
               hq_in   = {hq_prev[H-2:0], 1'b0};
            end
         end
      end

      // Restoring step for saturation; quotient bits shift in behind the dividend.
      always_comb begin
         srem_in = srem_prev;
         slo_in  = slo_prev;
         if (i < C) begin
            if (strial >= {1'b0, sdiv_prev}) begin
               srem_in = C'(strial - {1'b0, sdiv_prev});
               slo_in  = {slo_prev[C-2:0], 1'b1};
            end else begin
               srem_in = strial[C-1:0];
               slo_in  = {slo_prev[C-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[i] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[i] <= valid_prev;
         end
         if (adv) begin
            dv_hrem_ff[i]  <= hrem_in;
            dv_hdiv_ff[i]  <= hdiv_prev;
            dv_hq_ff[i]    <= hq_in;
            dv_srem_ff[i]  <= srem_in;
            dv_slo_ff[i]   <= slo_in;
            dv_sdiv_ff[i]  <= sdiv_prev;
            dv_mx_ff[i]    <= mx_prev;
            dv_alpha_ff[i] <= alpha_prev;
         end
      end
   end

   // ---------------- Result packing from the last divider stage.
   assign rsp_tvalid = dv_valid_ff[DIV_STEPS-1];

   always_comb begin
      rsp_tdata               = '0;
      rsp_tdata[0 +: H]       = dv_hq_ff[DIV_STEPS-1];
      rsp_tdata[H +: C]       = dv_slo_ff[DIV_STEPS-1];
      rsp_tdata[H + C +: C]   = dv_mx_ff[DIV_STEPS-1];
      rsp_tdata[H + 2*C +: C] = dv_alpha_ff[DIV_STEPS-1];
   end

   // ---------------- Assertions.
   `R2H_ASSERT_ALWAYS(a_reset_empties, $past(reset) |-> !rsp_tvalid, "output valid right after reset")
   `R2H_ASSERT(a_black_is_zero, rsp_tvalid && rsp_tdata[H + C +: C] == '0 |-> rsp_tdata[0 +: H + C] == '0, "black pixel with nonzero hue or saturation")
   `R2H_ASSERT(a_hue_rem_bound, dv_valid_ff[DIV_STEPS-1] |-> dv_hrem_ff[DIV_STEPS-1] < dv_hdiv_ff[DIV_STEPS-1], "hue remainder reached the divisor")
   `R2H_ASSERT(a_gray_numerator, s3_valid_ff && s3_hdiv_ff == HD_W'(1) |-> s3_num_ff == '0, "gray pixel with nonzero hue numerator")

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for rgb_to_hsv: drives RGBA pixels, predicts HSVA results.
// Depends on r2h_pkg.sv and rgb_to_hsv.sv (with its macro header) only.
`default_nettype none

module tb;

   // Pixel and result layouts, last field in the lowest bits.
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      logic [7:0]  alpha_out;
      logic [7:0]  value;
      logic [7:0]  saturation;
      logic [15:0] hue;
   } hsv_type;

   typedef struct {
      pixel_type px;
      bit        typed;
      hsv_type   hsv;
   } pixel_row_type;

   localparam int RANDOM_PIXELS = 1500;
   localparam int QUIET_PIXELS  = 250;
   localparam int DRAIN_CYCLES  = 60;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 300000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // red, green, blue, alpha
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // hue, saturation, value, alpha_out
   logic [39:0] rsp_tdata;

   hsv_type hsv_pending[$];
   int      err_count   = 0;
   int      pixels_sent = 0;
   bit      quiet       = 1'b0;

   rgb_to_hsv DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Expected conversion of one pixel.
   function automatic hsv_type hsv_of(input pixel_type px);
      logic [31:0]         r32, g32, b32, top, bottom, chroma, numer;
      r2h_pkg::sector_type sect;
      hsv_type             res;
      r32 = 32'(px.red);
      g32 = 32'(px.green);
      b32 = 32'(px.blue);
      top = r32;
      if (g32 > top) top = g32;
      if (b32 > top) top = b32;
      bottom = r32;
      if (g32 < bottom) bottom = g32;
      if (b32 < bottom) bottom = b32;
      chroma = top - bottom;
      // Largest channel picks the sector; ties go red, then green.
      if (r32 == top) sect = r2h_pkg::SECT_RED;
      else if (g32 == top) sect = r2h_pkg::SECT_GREEN;
      else sect = r2h_pkg::SECT_BLUE;
      res.hue        = '0;
      res.saturation = '0;
      res.value      = top[7:0];
      res.alpha_out  = px.alpha;
      if (chroma != 0) begin
         unique case (sect)
            r2h_pkg::SECT_RED: begin
               numer = (g32 >= b32) ? g32 - b32 : 6 * chroma - (b32 - g32);
            end
            r2h_pkg::SECT_GREEN: begin
               numer = 2 * chroma + b32 - r32;
            end
            default: begin
               numer = 4 * chroma + r32 - g32;
            end
         endcase
         res.hue = 16'((numer << 16) / (6 * chroma));
      end
      if (top != 0) res.saturation = 8'((chroma * 255) / top);
      return res;
   endfunction

   // Random pixel, biased toward grays, ties and channel extremes.
   function automatic pixel_type random_pixel();
      pixel_type px;
      int        mode;
      px   = pixel_type'($urandom);
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
         px.green = px.red;
         px.blue  = px.red;
      end else if (mode == 1) begin
         px.green = px.red;
      end else if (mode == 2) begin
         px.blue = px.green;
      end else if (mode == 3) begin
         px.red = px.blue;
      end else if (mode == 4) begin
         px.red   = $urandom_range(0, 1) ? 8'hff : 8'h00;
         px.green = $urandom_range(0, 1) ? 8'hfe : 8'h01;
         px.blue  = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
      return px;
   endfunction

   // Offer one pixel and record its expected result once the transaction completes.
   task automatic offer_pixel(input pixel_type px, input bit typed, input hsv_type typed_hsv);
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      hsv_pending.push_back(typed ? typed_hsv : hsv_of(px));
      pixels_sent++;
   endtask

   // Occasional idle burst on the request side.
   task automatic maybe_idle();
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Stimulus: directed table, then random pixels, then drain.
   initial begin
      pixel_row_type directed[] = '{
         '{'{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd0}, 1'b1,
           '{hue: 16'd0, saturation: 8'd0, value: 8'd0, alpha_out: 8'd0}},
         '{'{red: 8'd255, green: 8'd255, blue: 8'd255, alpha: 8'd255}, 1'b1,
           '{hue: 16'd0, saturation: 8'd0, value: 8'd255, alpha_out: 8'd255}},
         '{'{red: 8'd128, green: 8'd128, blue: 8'd128, alpha: 8'h5a}, 1'b1,
           '{hue: 16'd0, saturation: 8'd0, value: 8'd128, alpha_out: 8'h5a}},
         '{'{red: 8'd1, green: 8'd1, blue: 8'd1, alpha: 8'haa}, 1'b1,
           '{hue: 16'd0, saturation: 8'd0, value: 8'd1, alpha_out: 8'haa}},
         '{'{red: 8'd255, green: 8'd0, blue: 8'd0, alpha: 8'd255}, 1'b1,
           '{hue: 16'd0, saturation: 8'd255, value: 8'd255, alpha_out: 8'd255}},
         '{'{red: 8'd0, green: 8'd255, blue: 8'd0, alpha: 8'h0f}, 1'b1,
           '{hue: 16'd21845, saturation: 8'd255, value: 8'd255, alpha_out: 8'h0f}},
         '{'{red: 8'd0, green: 8'd0, blue: 8'd255, alpha: 8'hf0}, 1'b1,
           '{hue: 16'd43690, saturation: 8'd255, value: 8'd255, alpha_out: 8'hf0}},
         '{'{red: 8'd255, green: 8'd255, blue: 8'd0, alpha: 8'h55}, 1'b1,
           '{hue: 16'd10922, saturation: 8'd255, value: 8'd255, alpha_out: 8'h55}},
         '{'{red: 8'd0, green: 8'd255, blue: 8'd255, alpha: 8'h33}, 1'b1,
           '{hue: 16'd32768, saturation: 8'd255, value: 8'd255, alpha_out: 8'h33}},
         '{'{red: 8'd255, green: 8'd0, blue: 8'd255, alpha: 8'hcc}, 1'b1,
           '{hue: 16'd54613, saturation: 8'd255, value: 8'd255, alpha_out: 8'hcc}},
         '{'{red: 8'd255, green: 8'd0, blue: 8'd1, alpha: 8'd1}, 1'b0, '0},
         '{'{red: 8'd1, green: 8'd0, blue: 8'd0, alpha: 8'd2}, 1'b0, '0},
         '{'{red: 8'd0, green: 8'd1, blue: 8'd0, alpha: 8'd4}, 1'b0, '0},
         '{'{red: 8'd0, green: 8'd0, blue: 8'd1, alpha: 8'd8}, 1'b0, '0},
         '{'{red: 8'd255, green: 8'd254, blue: 8'd254, alpha: 8'd16}, 1'b0, '0},
         '{'{red: 8'd255, green: 8'd255, blue: 8'd254, alpha: 8'd32}, 1'b0, '0},
         '{'{red: 8'd1, green: 8'd1, blue: 8'd0, alpha: 8'd64}, 1'b0, '0},
         '{'{red: 8'd0, green: 8'd200, blue: 8'd200, alpha: 8'd128}, 1'b0, '0},
         '{'{red: 8'd200, green: 8'd100, blue: 8'd100, alpha: 8'd127}, 1'b0, '0},
         '{'{red: 8'd128, green: 8'd64, blue: 8'd255, alpha: 8'h80}, 1'b0, '0},
         '{'{red: 8'd254, green: 8'd1, blue: 8'd127, alpha: 8'h7f}, 1'b0, '0},
         '{'{red: 8'd17, green: 8'd240, blue: 8'd3, alpha: 8'hfe}, 1'b0, '0}
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         maybe_idle();
         offer_pixel(directed[i].px, directed[i].typed, directed[i].hsv);
      end
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         if (i == RANDOM_PIXELS - QUIET_PIXELS) quiet = 1'b1;
         maybe_idle();
         offer_pixel(random_pixel(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      while (hsv_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Result side: random stalls, plus one long hold-off that backs up the pipeline.
   initial begin
      bit held_long;
      held_long = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!held_long && pixels_sent >= 300) begin
            held_long = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare each completed result transaction with the oldest expectation.
   always @(posedge clock) begin : check_results
      hsv_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (hsv_pending.size() == 0) begin
            $error("result with no pixel pending: %h", rsp_tdata);
            err_count++;
         end else begin
            want = hsv_pending.pop_front();
            if (got.hue !== want.hue) begin
               $error("hue: expected %0d, got %0d", want.hue, got.hue);
               err_count++;
            end
            if (got.saturation !== want.saturation) begin
               $error("saturation: expected %0d, got %0d", want.saturation, got.saturation);
               err_count++;
            end
            if (got.value !== want.value) begin
               $error("value: expected %0d, got %0d", want.value, got.value);
               err_count++;
            end
            if (got.alpha_out !== want.alpha_out) begin
               $error("alpha_out: expected %0d, got %0d", want.alpha_out, got.alpha_out);
               err_count++;
            end
         end
      end
   end

   // Watchdog on total run length.
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
